// ----- design/bpc_pkg.sv -----
`timescale 1ns / 1ps

package bpc_pkg;

	// Widths of the request, result and configuration fields.
	localparam int unsigned REQ_TYPE_W = 2;
	localparam int unsigned BUTTON_W   = 3;
	localparam int unsigned NOW_W      = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Default build parameters.
	localparam int unsigned NUM_BUTTONS_DEF = 8;
	localparam int unsigned TIME_BITS_DEF   = 32;

	// Threshold values after reset, in milliseconds.
	localparam logic [CFG_DATA_W-1:0] SHORT_PRESS_RST = 16'd50;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] REPEAT_RST      = 16'd200;

	// Request codes.
	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_SHORT  = 2'd0,
		REQ_LONG   = 2'd1,
		REQ_REPEAT = 2'd2
	} req_type_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_PRESS = 2'd0,
		CFG_LONG_PRESS  = 2'd1,
		CFG_REPEAT      = 2'd2
	} cfg_index_t;

endpackage

// ----- design/bpc_if.sv -----
`timescale 1ns / 1ps

// Request channel: one button poll.
interface bpc_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [bpc_pkg::REQ_TYPE_W-1:0]         req_type;
	logic [bpc_pkg::BUTTON_W-1:0]           button;
	logic                                   pressed;
	logic [bpc_pkg::NOW_W-1:0]              now_ms;
	logic                                   display_blanked;

	modport source (output valid, req_type, button, pressed, now_ms, display_blanked,
		input ready);
	modport sink (input valid, req_type, button, pressed, now_ms, display_blanked,
		output ready);
endinterface

// Result channel: one answer per request.
interface bpc_res_if;
	logic valid;
	logic ready;
	logic event_res;
	logic wake_display;

	modport source (output valid, event_res, wake_display, input ready);
	modport sink (input valid, event_res, wake_display, output ready);
endinterface

// Configuration write channel.
interface bpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bpc_pkg::CFG_IDX_W-1:0]   index;
	logic [bpc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/button_press_classifier_unit.sv -----
`timescale 1ns / 1ps

// Button press classifier. Each request polls one button with a sampled level and the
// current millisecond time, and asks for a short-press query, a long-press query or a
// repeat mark; one result (event_res, wake_display) comes back for every request, in
// order. An accepted request is registered in the input stage; when the result register
// is free, the per-button state is read and updated and the answer is registered in the
// result register, from which it is offered.
// The per-button state lives in flip-flops, so a request to any button may follow in
// the very next cycle and one request is accepted per clock while the result side takes
// them. Thresholds are written through the configuration channel, which is always ready.
// Time differences wrap modulo 2^TIME_BITS.
module button_press_classifier_unit #(
	parameter int unsigned NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
	parameter int unsigned TIME_BITS   = bpc_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bpc_req_if.sink   req,
	bpc_res_if.source res,
	bpc_cfg_if.sink   cfg
);
	import bpc_pkg::*;

	// Only buttons reachable through the button field get storage.
	localparam int unsigned DEPTH = (NUM_BUTTONS > (1 << BUTTON_W)) ?
		(1 << BUTTON_W) : NUM_BUTTONS;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned TW    = TIME_BITS;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] short_press_q;
	logic [CFG_DATA_W-1:0] long_press_q;
	logic [CFG_DATA_W-1:0] repeat_q;

	// Per-button state.
	logic          short_armed_q   [DEPTH];
	logic          short_timing_q  [DEPTH];
	logic [TW-1:0] short_start_q   [DEPTH];
	logic          long_armed_q    [DEPTH];
	logic          long_timing_q   [DEPTH];
	logic [TW-1:0] long_start_q    [DEPTH];
	logic          repeat_active_q [DEPTH];
	logic [TW-1:0] repeat_start_q  [DEPTH];

	// Input stage.
	logic                  valid_s1;
	logic [REQ_TYPE_W-1:0] req_type_s1;
	logic [BUTTON_W-1:0]   button_s1;
	logic                  pressed_s1;
	logic [TW-1:0]         now_s1;
	logic                  blanked_s1;

	// Result stage.
	logic valid_s2;
	logic event_s2;
	logic wake_s2;

	// Handshake and datapath signals.
	logic                  out_free;
	logic                  adv_s1;
	logic [IDX_W-1:0]      idx;
	logic                  in_range;
	logic                  is_long;
	logic                  sel_armed;
	logic                  sel_timing;
	logic [TW-1:0]         sel_start;
	logic [CFG_DATA_W-1:0] sel_limit;
	logic                  begin_hold;
	logic [TW-1:0]         start_nxt;
	logic                  timing_nxt;
	logic                  armed_nxt;
	logic                  fire;
	logic [TW-1:0]         hold_time;
	logic [TW-1:0]         repeat_time;
	logic                  repeat_fire;
	logic                  event_nxt;
	logic                  wake_nxt;

	// Flow control: the input stage moves whenever the result register is free.
	assign out_free  = !valid_s2 || res.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	assign res.valid        = valid_s2;
	assign res.event_res    = event_s2;
	assign res.wake_display = wake_s2;

	// Decode the button of the request in the input stage.
	assign idx      = button_s1[IDX_W-1:0];
	assign in_range = ({1'b0, button_s1} < (BUTTON_W + 1)'(DEPTH));
	assign is_long  = (req_type_s1 == REQ_LONG);

	// Select the short or long qualifier of the addressed button.
	always_comb begin
		if (is_long) begin
			sel_armed  = long_armed_q[idx];
			sel_timing = long_timing_q[idx];
			sel_start  = long_start_q[idx];
			sel_limit  = long_press_q;
		end else begin
			sel_armed  = short_armed_q[idx];
			sel_timing = short_timing_q[idx];
			sel_start  = short_start_q[idx];
			sel_limit  = short_press_q;
		end
	end

	// Press qualifier: start timing on a fresh press, fire once past the limit,
	// re-arm on release.
	always_comb begin
		begin_hold = pressed_s1 && sel_armed && !sel_timing;
		start_nxt  = begin_hold ? now_s1 : sel_start;
		hold_time  = now_s1 - start_nxt;
		fire       = pressed_s1 && sel_armed && (hold_time > TW'(sel_limit));
		if (fire) begin
			armed_nxt  = 1'b0;
			timing_nxt = 1'b0;
		end else if (!pressed_s1) begin
			armed_nxt  = 1'b1;
			timing_nxt = 1'b0;
		end else begin
			armed_nxt  = sel_armed;
			timing_nxt = sel_timing || begin_hold;
		end
	end

	// Auto-repeat check for a long query that did not fire.
	assign repeat_time = now_s1 - repeat_start_q[idx];
	assign repeat_fire = repeat_active_q[idx] && pressed_s1 &&
		(repeat_time > TW'(repeat_q));

	// Result of the request.
	always_comb begin
		event_nxt = 1'b0;
		wake_nxt  = 1'b0;
		if (in_range) begin
			case (req_type_s1)
				REQ_SHORT: begin
					wake_nxt  = fire;
					event_nxt = fire && !blanked_s1;
				end
				REQ_LONG: begin
					wake_nxt  = fire;
					event_nxt = fire ? !blanked_s1 : repeat_fire;
				end
				default: begin
					event_nxt = 1'b0;
					wake_nxt  = 1'b0;
				end
			endcase
		end
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_press_q <= SHORT_PRESS_RST;
			long_press_q  <= LONG_PRESS_RST;
			repeat_q      <= REPEAT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SHORT_PRESS: short_press_q <= cfg.data;
				CFG_LONG_PRESS:  long_press_q  <= cfg.data;
				CFG_REPEAT:      repeat_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			button_s1   <= req.button;
			pressed_s1  <= req.pressed;
			now_s1      <= TW'(req.now_ms);
			blanked_s1  <= req.display_blanked;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			event_s2 <= 1'b0;
			wake_s2  <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				event_s2 <= event_nxt;
				wake_s2  <= wake_nxt;
			end
		end
	end

	// Per-button flags, updated as the request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				short_armed_q[i]   <= 1'b1;
				short_timing_q[i]  <= 1'b0;
				long_armed_q[i]    <= 1'b1;
				long_timing_q[i]   <= 1'b0;
				repeat_active_q[i] <= 1'b0;
			end
		end else if (adv_s1 && in_range) begin
			case (req_type_s1)
				REQ_SHORT: begin
					short_armed_q[idx]  <= armed_nxt;
					short_timing_q[idx] <= timing_nxt;
				end
				REQ_LONG: begin
					long_armed_q[idx]  <= armed_nxt;
					long_timing_q[idx] <= timing_nxt;
					if (!fire && !pressed_s1) begin
						repeat_active_q[idx] <= 1'b0;
					end
				end
				REQ_REPEAT: begin
					repeat_active_q[idx] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Per-button start times; each is only read after its flag shows it written.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_range) begin
			case (req_type_s1)
				REQ_SHORT:  short_start_q[idx]  <= start_nxt;
				REQ_LONG:   long_start_q[idx]   <= start_nxt;
				REQ_REPEAT: repeat_start_q[idx] <= now_s1;
				default: ;
			endcase
		end
	end

endmodule

// ----- tb/tb_button_press_classifier_unit.sv -----
`timescale 1ns / 1ps

// Expected answer of one button poll.
typedef struct packed {
	logic event_res;
	logic wake_display;
} poll_answer_t;

// Per-button press qualifier kept alongside the block, with the queue of answers still owed.
class press_answer_predictor;
	bit [15:0]    short_ms;
	bit [15:0]    long_ms;
	bit [15:0]    rpt_gap_ms;
	// Index 0 holds the short-press qualifier, index 1 the long-press one.
	bit           armed [2][8];
	bit           timing [2][8];
	bit [31:0]    start_ms [2][8];
	bit           rep_active [8];
	bit [31:0]    rep_start [8];
	poll_answer_t pending_answers [$];
	int           failures;

	function new();
		short_ms   = bpc_pkg::SHORT_PRESS_RST;
		long_ms    = bpc_pkg::LONG_PRESS_RST;
		rpt_gap_ms = bpc_pkg::REPEAT_RST;
		for (int k = 0; k < 2; k++) begin
			for (int b = 0; b < 8; b++) begin
				armed[k][b]    = 1'b1;
				timing[k][b]   = 1'b0;
				start_ms[k][b] = '0;
			end
		end
		for (int b = 0; b < 8; b++) begin
			rep_active[b] = 1'b0;
			rep_start[b]  = '0;
		end
		failures = 0;
	endfunction

	function void set_register(bpc_pkg::cfg_index_t idx, bit [15:0] val);
		case (idx)
			bpc_pkg::CFG_SHORT_PRESS: short_ms = val;
			bpc_pkg::CFG_LONG_PRESS:  long_ms = val;
			bpc_pkg::CFG_REPEAT:      rpt_gap_ms = val;
			default: ;
		endcase
	endfunction

	// Starts timing at the start of a press, fires once past the limit and re-arms on release.
	function bit qualify(int k, int b, bit lvl, bit [31:0] now, bit [15:0] limit);
		bit [31:0] held;
		if (lvl && armed[k][b] && !timing[k][b]) begin
			start_ms[k][b] = now;
			timing[k][b]   = 1'b1;
		end
		held = now - start_ms[k][b];
		if (lvl && armed[k][b] && (held > {16'd0, limit})) begin
			armed[k][b]  = 1'b0;
			timing[k][b] = 1'b0;
			return 1'b1;
		end
		if (!lvl) begin
			armed[k][b]  = 1'b1;
			timing[k][b] = 1'b0;
		end
		return 1'b0;
	endfunction

	function void note_request(bpc_pkg::req_type_t kind, bit [2:0] btn, bit lvl,
		bit [31:0] now, bit blank);
		poll_answer_t ans;
		bit [31:0]    since_mark;
		ans = '0;
		case (kind)
			bpc_pkg::REQ_SHORT: begin
				if (qualify(0, btn, lvl, now, short_ms)) begin
					ans.wake_display = 1'b1;
					ans.event_res    = !blank;
				end
			end
			bpc_pkg::REQ_LONG: begin
				if (qualify(1, btn, lvl, now, long_ms)) begin
					ans.wake_display = 1'b1;
					ans.event_res    = !blank;
				end else begin
					// Auto-repeat: never wakes the display, ignores blanking.
					if (!lvl)
						rep_active[btn] = 1'b0;
					since_mark = now - rep_start[btn];
					if (rep_active[btn] && lvl && (since_mark > {16'd0, rpt_gap_ms}))
						ans.event_res = 1'b1;
				end
			end
			bpc_pkg::REQ_REPEAT: begin
				rep_start[btn]  = now;
				rep_active[btn] = 1'b1;
			end
			default: ;
		endcase
		pending_answers.push_back(ans);
	endfunction

	function void check_answer(logic ev, logic wake);
		poll_answer_t want;
		if (pending_answers.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("%0t: result with no request outstanding: event_res %b wake_display %b",
					$realtime, ev, wake);
			return;
		end
		want = pending_answers.pop_front();
		if (ev !== want.event_res || wake !== want.wake_display) begin
			failures++;
			if (failures <= 10)
				$display("%0t: mismatch: event_res %b (expected %b), wake_display %b (expected %b)",
					$realtime, ev, want.event_res, wake, want.wake_display);
		end
	endfunction

	function int pending();
		return pending_answers.size();
	endfunction
endclass

module tb_button_press_classifier_unit;
	import bpc_pkg::*;

	// Codes outside the defined sets, used to check that they are ignored.
	localparam req_type_t  REQ_UNUSED = req_type_t'(2'd3);
	localparam cfg_index_t CFG_UNUSED = cfg_index_t'(2'd3);

	logic clk;
	logic arst_n;

	bpc_req_if req_ch ();
	bpc_res_if res_ch ();
	bpc_cfg_if cfg_ch ();

	button_press_classifier_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	press_answer_predictor sb = new();

	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	bit [31:0] sim_ms;
	bit        level [8];
	int        focus_btn;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: sample at the edge, check accepted results, then choose the next ready.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				sb.check_answer(res_ch.event_res, res_ch.wake_display);
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one request, with optional idle cycles in front, and waits for it to be taken.
	task automatic send_request(req_type_t kind, logic [2:0] btn, logic lvl, logic [31:0] now,
		logic blank);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= kind;
		req_ch.button          <= btn;
		req_ch.pressed         <= lvl;
		req_ch.now_ms          <= now;
		req_ch.display_blanked <= blank;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		sb.note_request(kind, btn, lvl, now, blank);
	endtask

	task automatic write_register(cfg_index_t idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		sb.set_register(idx, val);
	endtask

	// Writes all three thresholds and one write to the unused index.
	task automatic program_thresholds(logic [15:0] s, logic [15:0] l, logic [15:0] r);
		write_register(CFG_SHORT_PRESS, s);
		write_register(CFG_LONG_PRESS, l);
		write_register(CFG_REPEAT, r);
		write_register(CFG_UNUSED, 16'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// Stops offering requests and waits until every answer has arrived.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly held and released buttons polled over advancing time, with some noise.
	task automatic run_random(int count);
		int        span;
		int        step;
		int        roll;
		req_type_t kind;
		span = sb.short_ms;
		if (sb.long_ms > span)
			span = sb.long_ms;
		if (sb.rpt_gap_ms > span)
			span = sb.rpt_gap_ms;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 5) begin
				send_request(req_type_t'($urandom_range(3)), 3'($urandom_range(7)),
					1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
			end else begin
				roll = $urandom_range(99);
				if (roll == 0)
					sim_ms = sim_ms + $urandom;
				else if (roll < 10)
					step = $urandom_range(2 * span + 100);
				else
					step = $urandom_range(span / 4 + 5);
				if (roll != 0)
					sim_ms = sim_ms + 32'(step);
				if ($urandom_range(99) < 25)
					focus_btn = $urandom_range(7);
				if ($urandom_range(99) < 15)
					level[focus_btn] = !level[focus_btn];
				roll = $urandom_range(99);
				if (roll < 45)
					kind = REQ_SHORT;
				else if (roll < 85)
					kind = REQ_LONG;
				else if (roll < 97)
					kind = REQ_REPEAT;
				else
					kind = REQ_UNUSED;
				send_request(kind, 3'(focus_btn), level[focus_btn], sim_ms,
					$urandom_range(99) < 20);
			end
		end
	endtask

	// Main sequence: reset, directed polls, then random phases under different thresholds.
	initial begin
		logic [31:0] t0;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.req_type        <= REQ_SHORT;
		req_ch.button          <= '0;
		req_ch.pressed         <= 1'b0;
		req_ch.now_ms          <= '0;
		req_ch.display_blanked <= 1'b0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.index           <= CFG_SHORT_PRESS;
		cfg_ch.data            <= '0;
		sim_ms    = $urandom;
		focus_btn = 0;
		for (int b = 0; b < 8; b++)
			level[b] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short press across the time wrap: exactly at the limit, just past it, then held.
		t0 = 32'hFFFF_FFE0;
		send_request(REQ_SHORT, 3'd0, 1'b1, t0, 1'b0);
		send_request(REQ_SHORT, 3'd0, 1'b1, t0 + 32'd50, 1'b0);
		send_request(REQ_SHORT, 3'd0, 1'b1, t0 + 32'd51, 1'b0);
		send_request(REQ_SHORT, 3'd0, 1'b1, t0 + 32'd60, 1'b0);
		// Release re-arms; a fire while blanked only wakes the display.
		send_request(REQ_SHORT, 3'd0, 1'b0, t0 + 32'd70, 1'b0);
		send_request(REQ_SHORT, 3'd0, 1'b1, t0 + 32'd80, 1'b1);
		send_request(REQ_SHORT, 3'd0, 1'b1, t0 + 32'd200, 1'b1);
		// Long press, then repeat mark and auto-repeat at and past its limit.
		send_request(REQ_LONG, 3'd7, 1'b1, 32'd0, 1'b0);
		send_request(REQ_LONG, 3'd7, 1'b1, 32'd1000, 1'b0);
		send_request(REQ_LONG, 3'd7, 1'b1, 32'd1001, 1'b1);
		send_request(REQ_REPEAT, 3'd7, 1'b1, 32'd1001, 1'b0);
		send_request(REQ_LONG, 3'd7, 1'b1, 32'd1201, 1'b0);
		send_request(REQ_LONG, 3'd7, 1'b1, 32'd1202, 1'b0);
		send_request(REQ_LONG, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
		// Release ends auto-repeat.
		send_request(REQ_LONG, 3'd7, 1'b0, 32'd3000, 1'b0);
		send_request(REQ_LONG, 3'd7, 1'b1, 32'd5000, 1'b0);
		// Unused request type and a mark on a released button.
		send_request(REQ_UNUSED, 3'd3, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_request(REQ_REPEAT, 3'd3, 1'b0, 32'd0, 1'b0);
		send_request(REQ_LONG, 3'd3, 1'b1, 32'd500, 1'b0);
		send_request(REQ_SHORT, 3'd5, 1'b1, 32'h8000_0000, 1'b0);
		send_request(REQ_SHORT, 3'd5, 1'b1, 32'h8000_0000, 1'b0);
		drain();

		for (int p = 1; p <= 6; p++) begin
			case (p)
				1, 5: begin
					send_idle_pct  = 49;
					recv_stall_pct = 0;
				end
				2, 6: begin
					send_idle_pct  = 0;
					recv_stall_pct = 49;
				end
				3: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			case (p)
				1: program_thresholds(16'd0, 16'd0, 16'd0);
				2: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
				4: program_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
				default: program_thresholds(16'($urandom_range(200)), 16'($urandom_range(2000)),
					16'($urandom_range(500)));
			endcase
			run_random(155);
			drain();
		end

		if (sb.pending() != 0)
			$display("%0d expected results never arrived", sb.pending());
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
